// ===== hw/rtl/vda_pkg.sv =====
package vda_pkg;

  localparam int DEF_X_VOXELS   = 32;
  localparam int DEF_Y_VOXELS   = 32;
  localparam int DEF_Z_VOXELS   = 32;
  localparam int DEF_SIGMA_MULT = 2;

  localparam int IDX_W   = 5;
  localparam int E_W     = 32;
  localparam int SUM_W   = 56;
  localparam int SQ_W    = 64;
  localparam int CNT_W   = 32;
  localparam int INTV_W  = 20;
  localparam int PCT_W   = 32;
  localparam int PROD_W  = 160;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MON_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MON_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MON_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd4;

  localparam logic [IDX_W-1:0]  RST_MON_X     = 5'd16;
  localparam logic [IDX_W-1:0]  RST_MON_Y     = 5'd16;
  localparam logic [IDX_W-1:0]  RST_MON_Z     = 5'd0;
  localparam logic [PCT_W-1:0]  RST_TOLERANCE = 32'd65536;
  localparam logic [INTV_W-1:0] RST_INTERVAL  = 20'd10000;

  typedef struct packed {
    logic [IDX_W-1:0] vox_x;
    logic [IDX_W-1:0] vox_y;
    logic [IDX_W-1:0] vox_z;
    logic [E_W-1:0]   energy;
    logic             last_of_event;
  } in_item_t;

  typedef struct packed {
    logic             check_done;
    logic [PCT_W-1:0] uncertainty_pct;
    logic             undefined_result;
    logic             abort_run;
    logic [CNT_W-1:0] events_seen;
  } out_item_t;

endpackage

// ===== hw/rtl/vda_store.sv =====
module vda_store #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  logic                      clk,
  input  logic                      rst_n,
  output logic                      clr_busy,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [vda_pkg::SUM_W-1:0] rd_sum,
  output logic [vda_pkg::SQ_W-1:0]  rd_sq,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [vda_pkg::SUM_W-1:0] wr_sum,
  input  logic [vda_pkg::SQ_W-1:0]  wr_sq
);
  import vda_pkg::*;

  logic [SUM_W-1:0] sum_mem [DEPTH];
  logic [SQ_W-1:0]  sq_mem  [DEPTH];
  logic [ADDR_W:0]  clr_cnt_r;
  logic [SUM_W-1:0] rd_sum_r;
  logic [SQ_W-1:0]  rd_sq_r;

  assign clr_busy = (clr_cnt_r < (ADDR_W+1)'(DEPTH));

  // clearing pass after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clr_busy) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      sum_mem[clr_cnt_r[ADDR_W-1:0]] <= '0;
      sq_mem[clr_cnt_r[ADDR_W-1:0]]  <= '0;
    end else if (wr_en) begin
      sum_mem[wr_addr] <= wr_sum;
      sq_mem[wr_addr]  <= wr_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sum_r <= sum_mem[rd_addr];
      rd_sq_r  <= sq_mem[rd_addr];
    end
  end

  assign rd_sum = rd_sum_r;
  assign rd_sq  = rd_sq_r;

endmodule

// ===== hw/rtl/vda_unc.sv =====
module vda_unc #(
  parameter int SIGMA_MULT = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [vda_pkg::SUM_W-1:0] d_in,
  input  logic [vda_pkg::SQ_W-1:0]  q_in,
  input  logic [vda_pkg::CNT_W-1:0] n_in,
  output logic                      done,
  output logic [vda_pkg::PCT_W-1:0] unc,
  output logic                      undef
);
  import vda_pkg::*;

  localparam longint unsigned K_VAL = longint'(SIGMA_MULT) * 100 * 65536;
  localparam logic [63:0] K2 = 64'(K_VAL * K_VAL);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DCHK = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [1:0] P_NQ  = 2'd0;
  localparam logic [1:0] P_D2  = 2'd1;
  localparam logic [1:0] P_RHS = 2'd2;
  localparam logic [1:0] P_DEN = 2'd3;

  logic [2:0]        st_r;
  logic [1:0]        ph_r;
  logic [PROD_W-1:0] a_r, p_r, nq_r, d2_r, rhs_r, den_r, rem_r;
  logic [63:0]       b_r, quo_r;
  logic [5:0]        cnt_r;
  logic [CNT_W-1:0]  n_r;
  logic [34:0]       srem_r;
  logic [PCT_W-1:0]  root_r;
  logic [PCT_W-1:0]  unc_r;
  logic              undef_r;

  logic [PROD_W-1:0] p_add, div_r2;
  logic              div_ge;
  logic [34:0]       sq_r4, sq_trial;
  logic              sq_ge;

  assign p_add    = b_r[0] ? (p_r + a_r) : p_r;
  assign div_r2   = {rem_r[PROD_W-2:0], rhs_r[63]};
  assign div_ge   = (div_r2 >= den_r);
  assign sq_r4    = {srem_r[32:0], quo_r[63:62]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = (sq_r4 >= sq_trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (start) begin
            n_r <= n_in;
            if (d_in == '0 || n_in <= CNT_W'(1)) begin
              unc_r   <= '0;
              undef_r <= 1'b1;
              st_r    <= ST_DONE;
            end else begin
              a_r  <= PROD_W'(q_in);
              b_r  <= 64'(n_in);
              p_r  <= '0;
              ph_r <= P_NQ;
              st_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (b_r == '0) begin
            p_r <= '0;
            case (ph_r)
              P_NQ: begin
                nq_r <= p_r;
                a_r  <= PROD_W'(d_in);
                b_r  <= 64'(d_in);
                ph_r <= P_D2;
              end
              P_D2: begin
                d2_r <= p_r;
                if (nq_r <= p_r) begin
                  unc_r   <= '0;
                  undef_r <= 1'b0;
                  st_r    <= ST_DONE;
                end else begin
                  a_r  <= nq_r - p_r;
                  b_r  <= K2;
                  ph_r <= P_RHS;
                end
              end
              P_RHS: begin
                rhs_r <= p_r;
                a_r   <= d2_r;
                b_r   <= 64'(n_r - 1'b1);
                ph_r  <= P_DEN;
              end
              default: begin
                den_r <= p_r;
                st_r  <= ST_DCHK;
              end
            endcase
          end else begin
            p_r <= p_add;
            a_r <= a_r << 1;
            b_r <= b_r >> 1;
          end
        end
        ST_DCHK: begin
          undef_r <= 1'b0;
          if ((rhs_r >> 64) >= den_r) begin
            unc_r <= '1;
            st_r  <= ST_DONE;
          end else begin
            rem_r <= rhs_r >> 64;
            cnt_r <= 6'd63;
            st_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= div_ge ? (div_r2 - den_r) : div_r2;
          quo_r <= {quo_r[62:0], div_ge};
          rhs_r <= rhs_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            cnt_r  <= 6'd31;
            srem_r <= '0;
            root_r <= '0;
            st_r   <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          srem_r <= sq_ge ? (sq_r4 - sq_trial) : sq_r4;
          root_r <= {root_r[PCT_W-2:0], sq_ge};
          quo_r  <= quo_r << 2;
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            st_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ph_r == P_DEN && !undef_r && unc_r != '1 && quo_r == '0 && cnt_r == '1) begin
            unc_r <= root_r;
          end
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // the square root lands in root_r on the last sqrt step
  logic from_sqrt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_sqrt_r <= 1'b0;
    end else if (st_r == ST_SQRT) begin
      from_sqrt_r <= 1'b1;
    end else if (st_r == ST_IDLE) begin
      from_sqrt_r <= 1'b0;
    end
  end

  assign done  = (st_r == ST_DONE);
  assign unc   = from_sqrt_r ? root_r : unc_r;
  assign undef = undef_r;

endmodule

// ===== hw/rtl/voxel_dose_accumulator_with_convergence.sv =====
// channel  direction  ports
// in       input      in_valid, in_ready, in_data (in_item_t)
// out      output     out_valid, out_ready, out_data (out_item_t)
// cfg      input      cfg_valid, cfg_ready, cfg_index, cfg_data
// a deposit passes through accept, memory read, read-modify-write and result load
// a check adds a monitor read, the shift-add multiplies, the divider and the sqrt
// unit
// after reset a clearing pass over all X*Y*Z entries runs before the first input transfer
// a waiting result does not block the next input transfer
module voxel_dose_accumulator_with_convergence #(
  parameter int X_VOXELS   = vda_pkg::DEF_X_VOXELS,
  parameter int Y_VOXELS   = vda_pkg::DEF_Y_VOXELS,
  parameter int Z_VOXELS   = vda_pkg::DEF_Z_VOXELS,
  parameter int SIGMA_MULT = vda_pkg::DEF_SIGMA_MULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  vda_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output vda_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vda_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vda_pkg::*;

  localparam int VOXELS = X_VOXELS * Y_VOXELS * Z_VOXELS;
  localparam int ADDR_W = (VOXELS > 1) ? $clog2(VOXELS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_WR    = 3'd2;
  localparam logic [2:0] S_MRD   = 3'd3;
  localparam logic [2:0] S_MWAIT = 3'd4;
  localparam logic [2:0] S_CALC  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]        st_r;
  in_item_t          item_r;
  logic [63:0]       e2_r;
  logic [IDX_W-1:0]  mon_x_r, mon_y_r, mon_z_r;
  logic [PCT_W-1:0]  tol_r;
  logic [INTV_W-1:0] intv_cfg_r, intv_r;
  logic [CNT_W-1:0]  events_r;
  logic              abort_r, done_r, undef_r;
  logic [PCT_W-1:0]  unc_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic              clr_busy, rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, dep_addr, mon_addr;
  logic [SUM_W-1:0]  rd_sum, d_mon;
  logic [SQ_W-1:0]   rd_sq, q_mon;
  logic [SUM_W:0]    sum_add;
  logic [SQ_W:0]     sq_add;
  logic [SUM_W-1:0]  wr_sum;
  logic [SQ_W-1:0]   wr_sq;
  logic              dep_in, mon_in, unc_start, unc_done, unc_undef;
  logic [PCT_W-1:0]  unc_val;
  logic [INTV_W:0]   intv_inc;
  logic [CNT_W-1:0]  events_nxt;
  logic              out_load;

  assign dep_in = (32'(item_r.vox_x) < X_VOXELS) && (32'(item_r.vox_y) < Y_VOXELS) &&
                  (32'(item_r.vox_z) < Z_VOXELS);
  assign mon_in = (32'(mon_x_r) < X_VOXELS) && (32'(mon_y_r) < Y_VOXELS) &&
                  (32'(mon_z_r) < Z_VOXELS);
  assign dep_addr = ADDR_W'((32'(item_r.vox_x) * Y_VOXELS + 32'(item_r.vox_y)) * Z_VOXELS
                            + 32'(item_r.vox_z));
  assign mon_addr = ADDR_W'((32'(mon_x_r) * Y_VOXELS + 32'(mon_y_r)) * Z_VOXELS
                            + 32'(mon_z_r));

  assign rd_en   = (st_r == S_RD) || (st_r == S_MRD);
  assign rd_addr = (st_r == S_MRD) ? mon_addr : dep_addr;
  assign wr_en   = (st_r == S_WR) && dep_in;

  assign sum_add = {1'b0, rd_sum} + (SUM_W+1)'(item_r.energy);
  assign sq_add  = {1'b0, rd_sq} + {1'b0, e2_r};
  assign wr_sum  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign wr_sq   = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];

  assign intv_inc   = {1'b0, intv_r} + 1'b1;
  assign events_nxt = (events_r == '1) ? events_r : events_r + 1'b1;

  assign d_mon     = mon_in ? rd_sum : '0;
  assign q_mon     = mon_in ? rd_sq : '0;
  assign unc_start = (st_r == S_MWAIT);

  assign in_ready  = (st_r == S_IDLE) && !clr_busy;
  assign cfg_ready = 1'b1;
  assign out_load  = (st_r == S_OUT) && (!out_valid_r || out_ready);

  vda_store #(.DEPTH(VOXELS), .ADDR_W(ADDR_W)) u_store (
    .clk(clk), .rst_n(rst_n), .clr_busy(clr_busy),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_sum(rd_sum), .rd_sq(rd_sq),
    .wr_en(wr_en), .wr_addr(dep_addr), .wr_sum(wr_sum), .wr_sq(wr_sq)
  );

  vda_unc #(.SIGMA_MULT(SIGMA_MULT)) u_unc (
    .clk(clk), .rst_n(rst_n), .start(unc_start),
    .d_in(d_mon), .q_in(q_mon), .n_in(events_r),
    .done(unc_done), .unc(unc_val), .undef(unc_undef)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_x_r    <= RST_MON_X;
      mon_y_r    <= RST_MON_Y;
      mon_z_r    <= RST_MON_Z;
      tol_r      <= RST_TOLERANCE;
      intv_cfg_r <= RST_INTERVAL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MON_X:     mon_x_r    <= cfg_data[IDX_W-1:0];
        REG_MON_Y:     mon_y_r    <= cfg_data[IDX_W-1:0];
        REG_MON_Z:     mon_z_r    <= cfg_data[IDX_W-1:0];
        REG_TOLERANCE: tol_r      <= cfg_data[PCT_W-1:0];
        REG_INTERVAL:  intv_cfg_r <= cfg_data[INTV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      events_r <= '0;
      intv_r   <= '0;
      abort_r  <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item_r <= in_data;
            st_r   <= S_RD;
          end
        end
        S_RD: begin
          e2_r <= 64'(item_r.energy) * 64'(item_r.energy);
          st_r <= S_WR;
        end
        S_WR: begin
          done_r  <= 1'b0;
          undef_r <= 1'b0;
          unc_r   <= '0;
          st_r    <= S_OUT;
          if (item_r.last_of_event) begin
            events_r <= events_nxt;
            if (intv_inc >= {1'b0, intv_cfg_r}) begin
              intv_r <= '0;
              st_r   <= S_MRD;
            end else begin
              intv_r <= intv_inc[INTV_W-1:0];
            end
          end
        end
        S_MRD:   st_r <= S_MWAIT;
        S_MWAIT: st_r <= S_CALC;
        S_CALC: begin
          if (unc_done) begin
            done_r  <= 1'b1;
            undef_r <= unc_undef;
            unc_r   <= unc_val;
            if (!unc_undef && unc_val < tol_r) begin
              abort_r <= 1'b1;
            end
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.check_done       <= done_r;
      out_r.uncertainty_pct  <= unc_r;
      out_r.undefined_result <= undef_r;
      out_r.abort_run        <= abort_r;
      out_r.events_seen      <= events_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready) else $error("input taken during clearing pass");

  a_abort_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    abort_r |=> abort_r) else $error("abort flag dropped");

  a_undef_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.undefined_result |-> out_r.check_done)
    else $error("undefined result without check");

  a_no_write_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CALC) |-> !wr_en) else $error("store written during check");

endmodule

// ===== sim/voxel_dose_accumulator_with_convergence_test.sv =====
module voxel_dose_accumulator_with_convergence_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vda_pkg::*;

  localparam int                   LIMIT_CYCLES = 4_000_000;
  localparam int                   VOXEL_COUNT  = DEF_X_VOXELS * DEF_Y_VOXELS * DEF_Z_VOXELS;
  localparam logic [SUM_W-1:0]     SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [63:0]          PCT_K        = 64'(DEF_SIGMA_MULT) * 64'd100 * 64'd65536;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd5;
  localparam int                   PHASES       = 8;
  localparam int                   PHASE_ITEMS  = 144;

  typedef enum logic {ROW_DEPOSIT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              item;
    bit                    typed;
    out_item_t             result;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  voxel_dose_accumulator_with_convergence u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow of the dose store and counters
  logic [SUM_W-1:0]  dose_sum    [VOXEL_COUNT];
  logic [SQ_W-1:0]   dose_sq_sum [VOXEL_COUNT];
  logic [CNT_W-1:0]  evt_count;
  logic [INTV_W-1:0] intv_count;
  logic              abort_latch;
  logic [IDX_W-1:0]  mon_x, mon_y, mon_z;
  logic [PCT_W-1:0]  tol_pct;
  logic [INTV_W-1:0] check_intv;

  out_item_t pending_results[$];
  stim_row_t directed_rows[$];

  int err_count;
  int results_seen;
  int checks_seen;
  int undefined_seen;
  int deposits_sent;
  int cycle_count;
  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_left;

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %0s at result %0d: got %0h want %0h", field, results_seen, got, want);
    err_count++;
  endtask

  function automatic logic [PCT_W-1:0] rel_uncertainty(input logic [SUM_W-1:0] d,
                                                       input logic [SQ_W-1:0] q,
                                                       input logic [CNT_W-1:0] n,
                                                       output logic undef);
    logic [255:0] nq, d2, rhs, den, trial;
    logic [PCT_W-1:0] u, t;
    u = '0;
    undef = 1'b0;
    if (d == 0 || n <= 1) begin
      undef = 1'b1;
      return '0;
    end
    nq = 256'(n) * 256'(q);
    d2 = 256'(d) * 256'(d);
    if (nq <= d2) return '0;
    rhs = 256'(PCT_K * PCT_K) * (nq - d2);
    den = 256'(n - 1) * d2;
    for (int b = PCT_W - 1; b >= 0; b--) begin
      t = u | (32'd1 << b);
      trial = 256'(t) * 256'(t) * den;
      if (trial <= rhs) u = t;
    end
    return u;
  endfunction

  function automatic out_item_t accumulate_deposit(in_item_t it);
    out_item_t r;
    int idx, m;
    logic [SUM_W:0] s;
    logic [SQ_W:0] sq;
    logic [SQ_W-1:0] e2;
    logic undef;
    r = '0;
    if (it.vox_x < DEF_X_VOXELS && it.vox_y < DEF_Y_VOXELS && it.vox_z < DEF_Z_VOXELS) begin
      idx = (int'(it.vox_x) * DEF_Y_VOXELS + int'(it.vox_y)) * DEF_Z_VOXELS + int'(it.vox_z);
      s = {1'b0, dose_sum[idx]} + (SUM_W + 1)'(it.energy);
      dose_sum[idx] = (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
      e2 = 64'(it.energy) * 64'(it.energy);
      sq = {1'b0, dose_sq_sum[idx]} + {1'b0, e2};
      dose_sq_sum[idx] = sq[SQ_W] ? {SQ_W{1'b1}} : sq[SQ_W-1:0];
    end
    if (it.last_of_event) begin
      if (evt_count != {CNT_W{1'b1}}) evt_count++;
      if (32'(intv_count) + 32'd1 >= 32'(check_intv)) begin
        intv_count = '0;
        r.check_done = 1'b1;
        if (mon_x < DEF_X_VOXELS && mon_y < DEF_Y_VOXELS && mon_z < DEF_Z_VOXELS) begin
          m = (int'(mon_x) * DEF_Y_VOXELS + int'(mon_y)) * DEF_Z_VOXELS + int'(mon_z);
          r.uncertainty_pct = rel_uncertainty(dose_sum[m], dose_sq_sum[m], evt_count, undef);
        end else begin
          r.uncertainty_pct = rel_uncertainty('0, '0, evt_count, undef);
        end
        r.undefined_result = undef;
        if (!undef && r.uncertainty_pct < tol_pct) abort_latch = 1'b1;
      end else begin
        intv_count = intv_count + 1'b1;
      end
    end
    r.abort_run = abort_latch;
    r.events_seen = evt_count;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MON_X:     mon_x = val[IDX_W-1:0];
      REG_MON_Y:     mon_y = val[IDX_W-1:0];
      REG_MON_Z:     mon_z = val[IDX_W-1:0];
      REG_TOLERANCE: tol_pct = val[PCT_W-1:0];
      REG_INTERVAL:  check_intv = val[INTV_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_deposit(in_item_t it, bit typed, out_item_t typed_result);
    out_item_t r;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    r = accumulate_deposit(it);
    pending_results.push_back(typed ? typed_result : r);
    deposits_sent++;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic in_item_t mk_dep(int x, int y, int z, logic [E_W-1:0] e, bit last);
    in_item_t it;
    it.vox_x = IDX_W'(x);
    it.vox_y = IDX_W'(y);
    it.vox_z = IDX_W'(z);
    it.energy = e;
    it.last_of_event = last;
    return it;
  endfunction

  function automatic out_item_t mk_res(bit done, bit undef, int events);
    out_item_t r;
    r = '0;
    r.check_done = done;
    r.undefined_result = undef;
    r.events_seen = CNT_W'(events);
    return r;
  endfunction

  function automatic void add_dep(in_item_t it, bit typed, out_item_t r);
    stim_row_t row;
    row.kind = ROW_DEPOSIT;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.item = it;
    row.typed = typed;
    row.result = r;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.item = '0;
    row.typed = 1'b0;
    row.result = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic in_item_t random_deposit(logic [E_W-1:0] base);
    in_item_t it;
    int pick;
    logic [E_W-1:0] jitter;
    pick = $urandom_range(99);
    it.vox_x = IDX_W'($urandom);
    it.vox_y = IDX_W'($urandom);
    it.vox_z = IDX_W'($urandom);
    it.energy = $urandom;
    it.last_of_event = ($urandom_range(2) == 0);
    if (pick < 60) begin
      it.vox_x = mon_x;
      it.vox_y = mon_y;
      it.vox_z = mon_z;
      jitter = base >> 3;
      it.energy = base - jitter + E_W'($urandom_range(0, 2 * jitter));
    end else if (pick < 72) begin
      it.vox_x = mon_x;
      it.vox_y = mon_y;
      it.vox_z = mon_z + 1'b1;
    end else if (pick < 76) begin
      it.energy = ($urandom_range(1) == 0) ? '0 : {E_W{1'b1}};
    end
    return it;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data.events_seen), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.check_done !== want.check_done)
          report_mismatch("check_done", 64'(out_data.check_done), 64'(want.check_done));
        if (out_data.uncertainty_pct !== want.uncertainty_pct)
          report_mismatch("uncertainty_pct", 64'(out_data.uncertainty_pct),
                          64'(want.uncertainty_pct));
        if (out_data.undefined_result !== want.undefined_result)
          report_mismatch("undefined_result", 64'(out_data.undefined_result),
                          64'(want.undefined_result));
        if (out_data.abort_run !== want.abort_run)
          report_mismatch("abort_run", 64'(out_data.abort_run), 64'(want.abort_run));
        if (out_data.events_seen !== want.events_seen)
          report_mismatch("events_seen", 64'(out_data.events_seen), 64'(want.events_seen));
        if (want.check_done) checks_seen++;
        if (want.check_done && want.undefined_result) undefined_seen++;
        results_seen++;
      end
    end
  end

  initial begin
    logic [PCT_W-1:0] tol_table [PHASES];
    logic [INTV_W-1:0] intv_table [PHASES];
    logic [E_W-1:0] base;
    in_item_t it;
    for (int i = 0; i < VOXEL_COUNT; i++) begin
      dose_sum[i] = '0;
      dose_sq_sum[i] = '0;
    end
    evt_count = '0;
    intv_count = '0;
    abort_latch = 1'b0;
    mon_x = RST_MON_X;
    mon_y = RST_MON_Y;
    mon_z = RST_MON_Z;
    tol_pct = RST_TOLERANCE;
    check_intv = RST_INTERVAL;
    idle_pct = 0;
    stall_pct = 0;

    add_dep(mk_dep(0, 0, 0, '0, 0), 1, mk_res(0, 0, 0));
    add_dep(mk_dep(31, 31, 31, {E_W{1'b1}}, 0), 1, mk_res(0, 0, 0));
    add_dep(mk_dep(31, 31, 31, {E_W{1'b1}}, 0), 1, mk_res(0, 0, 0));
    add_cfg(REG_MON_X, 32'd31);
    add_cfg(REG_MON_Y, 32'd31);
    add_cfg(REG_MON_Z, 32'd31);
    add_cfg(REG_INTERVAL, 32'd1);
    // single event at the check
    add_dep(mk_dep(5, 6, 7, 32'd100, 1), 1, mk_res(1, 1, 1));
    add_cfg(REG_MON_X, 32'd0);
    add_cfg(REG_MON_Y, 32'd0);
    add_cfg(REG_MON_Z, 32'd0);
    // monitored voxel holds a zero sum
    add_dep(mk_dep(1, 2, 3, 32'd7, 1), 1, mk_res(1, 1, 2));
    add_cfg(REG_INTERVAL, 32'd0);
    add_dep(mk_dep(0, 1, 0, 32'd9, 1), 1, mk_res(1, 1, 3));
    add_cfg(REG_MON_X, 32'd31);
    add_cfg(REG_MON_Y, 32'd31);
    add_cfg(REG_MON_Z, 32'd31);
    add_cfg(REG_TOLERANCE, 32'd0);
    // saturated square sum, negative numerator clamps to zero
    add_dep(mk_dep(31, 31, 31, 32'h0001_0000, 1), 1, mk_res(1, 0, 4));
    add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
    add_dep(mk_dep(31, 31, 31, 32'd1, 0), 0, '0);
    add_dep(mk_dep(31, 31, 30, 32'h8000_0000, 1), 0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_deposit(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    tol_table = '{32'd0, 32'd0, 32'd65536, 32'h0010_0000, $urandom, 32'd200 << 16,
                  $urandom, 32'hFFFF_FFFF};
    intv_table = '{20'd2, INTV_W'($urandom_range(2, 6)), 20'd3, 20'd0, 20'd4,
                   20'hFFFFF, 20'd2, 20'd5};

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_reg(REG_MON_X, $urandom);
      write_reg(REG_MON_Y, $urandom);
      write_reg(REG_MON_Z, (p == 1) ? 32'd0 : ((p == 2) ? 32'd31 : $urandom));
      write_reg(REG_TOLERANCE, tol_table[p]);
      write_reg(REG_INTERVAL, 32'(intv_table[p]));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      base = E_W'($urandom_range(32'h0000_1000, 32'h0100_0000));
      if (p == 2) hold_req = 400;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 5 && k == 70) wait_drained();
        it = random_deposit(base);
        send_deposit(it, 0, '0);
      end
    end

    wait_drained();
    repeat (400) @(posedge clk);

    $display("deposits %0d, results %0d, checks %0d (%0d undefined), abort %0b",
             deposits_sent, results_seen, checks_seen, undefined_seen, abort_latch);
    $display("covered saturation, single-event and zero-sum checks, and flow-control phases");
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
